@@ rtl/cdg_pkg.sv @@
// cdg_pkg: shared widths, register codes, job record and helpers for the
// central-difference gradient block. No dependencies.
package cdg_pkg;

    // field widths
    localparam int PIX_BITS    = 8;
    localparam int DIFF_BITS   = PIX_BITS + 1;
    localparam int MAG_BITS    = 10;
    localparam int COORD_BITS  = 10;
    localparam int DIM_BITS    = 11;
    // 4 * (dx^2 + dy^2) fits here
    localparam int SQ_BITS     = 2 * DIFF_BITS + 2;

    // frame size limits and reset values
    localparam int MIN_DIM     = 2;
    localparam int MAX_HEIGHT  = 1024;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd480;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // first trial bit of the square root, highest even power in range
    localparam logic [SQ_BITS-1:0] ROOT_TOP = {2'b01, {(SQ_BITS - 2){1'b0}}};

    typedef logic [PIX_BITS-1:0]          t_pix;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic [DIM_BITS-1:0]          t_dim;
    typedef logic [MAG_BITS-1:0]          t_mag;

    // configuration register indexes
    typedef logic [0:0] t_cfg_addr;
    localparam t_cfg_addr CFG_WIDTH  = 1'b0;
    localparam t_cfg_addr CFG_HEIGHT = 1'b1;

    // result slots of one pixel: upper-row result, left bottom, bottom corner
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_A = 2'd0;
    localparam t_sel SEL_B = 2'd1;
    localparam t_sel SEL_C = 2'd2;

    // one classified pixel: up to three results with their differences
    typedef struct packed {
        logic [2:0]  has;
        t_diff [2:0] dx;
        t_diff [2:0] dy;
        t_coord      row;
        t_coord      col;
    } t_job;

    // a minus b as a signed difference
    function automatic t_diff pix_diff(input t_pix a, input t_pix b);
        return t_diff'({1'b0, a} - {1'b0, b});
    endfunction

endpackage

@@ rtl/cdg_if.sv @@
// cdg_if: valid/ready channel interfaces for pixels, results and config writes.
// Depends on cdg_pkg.
interface cdg_pix_if import cdg_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface cdg_res_if import cdg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_diff  diff_x;
    t_diff  diff_y;
    t_mag   magnitude_q;
    t_coord out_row;
    t_coord out_col;
    logic   last_of_item;
    logic   end_of_frame;

    modport source (output valid, output diff_x, output diff_y, output magnitude_q,
                    output out_row, output out_col, output last_of_item,
                    output end_of_frame, input ready);
    modport sink   (input valid, input diff_x, input diff_y, input magnitude_q,
                    input out_row, input out_col, input last_of_item,
                    input end_of_frame, output ready);
endinterface

interface cdg_cfg_if import cdg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_addr addr;
    t_dim      data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/cdg_front.sv @@
// cdg_front: takes pixels, keeps the two line buffers and the raster position,
// and turns each pixel into one job record. Depends on cdg_pkg and cdg_if.
module cdg_front import cdg_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cdg_pix_if.sink i_pix,
    cdg_cfg_if.sink i_cfg,
    input  logic    i_full,
    output logic    o_push,
    output t_job    o_job
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    localparam logic FS_IDLE = 1'b0;
    localparam logic FS_WORK = 1'b1;

    logic r_state, n_state;
    t_dim r_width;
    t_dim r_height;
    t_coord r_row, n_row;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [COL_BITS-1:0] last_col;
    t_coord last_row;
    logic [COL_BITS-1:0] look_addr;

    // current pixel and its position
    t_pix r_pix;
    t_coord r_irow;
    logic [COL_BITS-1:0] r_icol;

    // line buffer read data and neighbour history
    t_pix r_recent_q;
    t_pix r_older_q;
    t_pix r_cur;
    t_pix r_cur_prev;
    t_pix r_prev;
    t_pix r_prev2;

    t_pix recent_mem [MAX_WIDTH];
    t_pix older_mem  [MAX_WIDTH];

    logic accept;
    logic cfg_wr;
    logic step_done;
    logic any_job;
    t_job job;

    // neighbour selection
    logic first_col, at_end, two_in, row_ge2, bottom;
    t_pix left_a, right_a, up_a, left_b;

    assign accept      = i_pix.valid && i_pix.ready;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign i_pix.ready = (r_state == FS_IDLE);
    assign i_cfg.ready = 1'b1;
    assign any_job     = |job.has;
    assign step_done   = (r_state == FS_WORK) && (!i_full || !any_job);
    assign o_push      = step_done && any_job;
    assign o_job       = job;

    // clamp the frame size
    always_comb begin
        priority if (r_width < t_dim'(MIN_DIM)) begin
            last_col = COL_BITS'(MIN_DIM - 1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            last_col = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_BITS'(r_width - t_dim'(1));
        end
        priority if (r_height < t_dim'(MIN_DIM)) begin
            last_row = COORD_BITS'(MIN_DIM - 1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            last_row = COORD_BITS'(MAX_HEIGHT - 1);
        end else begin
            last_row = COORD_BITS'(r_height - t_dim'(1));
        end
    end

    // raster position after this pixel
    always_comb begin
        if (r_col == last_col) begin
            n_col = '0;
            n_row = (r_row == last_row) ? '0 : r_row + t_coord'(1);
        end else begin
            n_col = r_col + COL_BITS'(1);
            n_row = r_row;
        end
    end

    // lookahead read: next column, or column 0 for the next row's first pixel
    assign look_addr = (r_col == last_col) ? '0 : r_col + COL_BITS'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_state = FS_WORK;
                end
            end
            FS_WORK: begin
                if (step_done) begin
                    n_state = FS_IDLE;
                end
            end
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (i_cfg.addr)
                    CFG_WIDTH:  r_width  <= i_cfg.data;
                    CFG_HEIGHT: r_height <= i_cfg.data;
                endcase
                r_row <= '0;
                r_col <= '0;
            end else if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // pixel capture and neighbour history
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_pix.pixel;
            r_irow <= r_row;
            r_icol <= r_col;
        end
        if (step_done) begin
            r_prev2    <= r_prev;
            r_prev     <= r_pix;
            r_cur_prev <= r_cur;
            r_cur      <= r_recent_q;
        end
    end

    // line buffers: read on accept, write back when the pixel is done
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_recent_q <= recent_mem[look_addr];
            r_older_q  <= older_mem[r_col];
        end
        if (step_done) begin
            recent_mem[r_icol] <= r_pix;
            older_mem[r_icol]  <= r_cur;
        end
    end

    // classify the pixel and form the differences
    always_comb begin
        first_col = (r_icol == '0);
        at_end    = (r_icol == last_col);
        two_in    = (32'(r_icol) >= 32'd2);
        row_ge2   = (r_irow >= t_coord'(2));
        bottom    = (r_irow == last_row);

        left_a  = first_col ? r_cur : r_cur_prev;
        right_a = at_end ? r_cur : r_recent_q;
        up_a    = row_ge2 ? r_older_q : r_cur;
        left_b  = two_in ? r_prev2 : r_prev;

        job.has[SEL_A] = (r_irow != '0);
        job.has[SEL_B] = bottom && !first_col;
        job.has[SEL_C] = bottom && at_end;

        job.dx[SEL_A] = pix_diff(right_a, left_a);
        job.dy[SEL_A] = pix_diff(r_pix, up_a);
        job.dx[SEL_B] = pix_diff(r_pix, left_b);
        job.dy[SEL_B] = pix_diff(r_prev, r_cur_prev);
        job.dx[SEL_C] = pix_diff(r_pix, r_prev);
        job.dy[SEL_C] = pix_diff(r_pix, r_cur);

        job.row = r_irow;
        job.col = COORD_BITS'(r_icol);
    end

endmodule

@@ rtl/cdg_queue.sv @@
// cdg_queue: small job fifo that decouples the front from the back.
// Depends on cdg_pkg.
module cdg_queue import cdg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wp;
    logic [QPTR_BITS-1:0] r_rp;
    logic [QPTR_BITS:0] r_count;

    assign o_full  = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_BITS + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_BITS + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

@@ rtl/cdg_back.sv @@
// cdg_back: expands each job into its results, squares the differences and
// takes the integer square root two bits a cycle. Depends on cdg_pkg, cdg_if.
module cdg_back import cdg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    cdg_res_if.source  o_res
);

    localparam logic [1:0] BS_IDLE   = 2'd0;
    localparam logic [1:0] BS_SQUARE = 2'd1;
    localparam logic [1:0] BS_ROOT   = 2'd2;
    localparam logic [1:0] BS_EMIT   = 2'd3;

    logic [1:0] r_state, n_state;
    t_job r_job;
    t_sel r_sel;
    t_sel first_sel, next_sel;
    logic has_later;

    // square and root datapath
    logic signed [2*DIFF_BITS-1:0] prod_x, prod_y;
    logic [2*DIFF_BITS-1:0] sq_sum;
    logic [SQ_BITS-1:0] r_v;
    logic [SQ_BITS-1:0] r_res;
    logic [SQ_BITS-1:0] r_bit;
    logic [SQ_BITS:0] trial;
    logic fits;

    // output register
    logic   r_out_valid;
    t_diff  r_out_dx;
    t_diff  r_out_dy;
    t_mag   r_out_mag;
    t_coord r_out_row;
    t_coord r_out_col;
    logic   r_out_last;
    logic   r_out_eof;
    logic   load;

    assign o_pop = (r_state == BS_IDLE) && i_valid;
    assign load  = (r_state == BS_EMIT) && (!r_out_valid || o_res.ready);

    // first result of the incoming job
    always_comb begin
        priority if (i_job.has[SEL_A]) begin
            first_sel = SEL_A;
        end else if (i_job.has[SEL_B]) begin
            first_sel = SEL_B;
        end else begin
            first_sel = SEL_C;
        end
    end

    // what follows the current result
    always_comb begin
        unique case (r_sel)
            SEL_A: begin
                has_later = r_job.has[SEL_B] | r_job.has[SEL_C];
                next_sel  = r_job.has[SEL_B] ? SEL_B : SEL_C;
            end
            SEL_B: begin
                has_later = r_job.has[SEL_C];
                next_sel  = SEL_C;
            end
            default: begin
                has_later = 1'b0;
                next_sel  = SEL_C;
            end
        endcase
    end

    // squares of the selected differences
    always_comb begin
        prod_x = r_job.dx[r_sel] * r_job.dx[r_sel];
        prod_y = r_job.dy[r_sel] * r_job.dy[r_sel];
        sq_sum = {1'b0, prod_x[2*DIFF_BITS-2:0]} + {1'b0, prod_y[2*DIFF_BITS-2:0]};
    end

    // one root step
    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign fits  = ({1'b0, r_v} >= trial);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_valid) begin
                    n_state = BS_SQUARE;
                end
            end
            BS_SQUARE: begin
                n_state = BS_ROOT;
            end
            BS_ROOT: begin
                if (r_bit[0]) begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (load) begin
                    n_state = has_later ? BS_SQUARE : BS_IDLE;
                end
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job, root iteration and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_sel <= first_sel;
        end
        if (r_state == BS_SQUARE) begin
            r_v   <= {sq_sum, 2'b00};
            r_res <= '0;
            r_bit <= ROOT_TOP;
        end
        if (r_state == BS_ROOT) begin
            if (fits) begin
                r_v   <= r_v - trial[SQ_BITS-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (load) begin
            r_out_dx   <= r_job.dx[r_sel];
            r_out_dy   <= r_job.dy[r_sel];
            r_out_mag  <= r_res[MAG_BITS-1:0];
            r_out_row  <= (r_sel == SEL_A) ? r_job.row - t_coord'(1) : r_job.row;
            r_out_col  <= (r_sel == SEL_B) ? r_job.col - t_coord'(1) : r_job.col;
            r_out_last <= !has_later;
            r_out_eof  <= (r_sel == SEL_C);
            if (has_later) begin
                r_sel <= next_sel;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.diff_x       = r_out_dx;
    assign o_res.diff_y       = r_out_dy;
    assign o_res.magnitude_q  = r_out_mag;
    assign o_res.out_row      = r_out_row;
    assign o_res.out_col      = r_out_col;
    assign o_res.last_of_item = r_out_last;
    assign o_res.end_of_frame = r_out_eof;

endmodule

@@ rtl/central_difference_gradient_magnitude_top.sv @@
// channel  | role   | beat carries
// i_pix    | sink   | pixel (8 bit gray, raster order)
// i_cfg    | sink   | addr (0 width, 1 height), data (11 bit)
// o_res    | source | diff_x, diff_y, magnitude_q, out_row, out_col, last_of_item, end_of_frame
//
// the front takes a pixel, reads the line buffers, then classifies it and writes the buffers
// back before it takes the next; it stalls only when the job queue is full.
// the back pops a job, then for each result runs its square step, 10 root steps and the
// handoff to the output register, which waits while o_res is stalled.
// reset is synchronous: 640 x 480, position 0,0; line buffers are not cleared.
// a stalled o_res holds its beat while the back keeps working on the next result.
module central_difference_gradient_magnitude_top import cdg_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdg_pix_if.sink    i_pix,
    cdg_cfg_if.sink    i_cfg,
    cdg_res_if.source  o_res
);

    t_job front_job;
    t_job queue_job;
    logic push;
    logic full;
    logic queue_valid;
    logic pop;

    // pixel intake and line buffers
    cdg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    // job queue
    cdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_job   (queue_job)
    );

    // magnitude and result output
    cdg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_job   (queue_job),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

@@ rtl/cdg_checker.sv @@
// cdg_checker: port-level checks on the result channel, bound to the top level.
// Depends on cdg_pkg.
module cdg_checker import cdg_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_res_valid,
    input logic   i_res_ready,
    input t_diff  i_diff_x,
    input t_diff  i_diff_y,
    input t_mag   i_magnitude_q,
    input t_coord i_out_row,
    input t_coord i_out_col,
    input logic   i_last_of_item,
    input logic   i_end_of_frame
);

    logic signed [2*DIFF_BITS-1:0] prod_x, prod_y;
    logic [SQ_BITS-1:0] sum4;
    logic [MAG_BITS:0] mag_p1;
    logic [2*MAG_BITS:0] lo_sq, hi_sq;

    // bounds of the rounded-down root
    always_comb begin
        prod_x = i_diff_x * i_diff_x;
        prod_y = i_diff_y * i_diff_y;
        sum4   = {({1'b0, prod_x[2*DIFF_BITS-2:0]} + {1'b0, prod_y[2*DIFF_BITS-2:0]}),
                  2'b00};
        mag_p1 = (MAG_BITS + 1)'(i_magnitude_q) + (MAG_BITS + 1)'(1);
        lo_sq  = (2*MAG_BITS + 1)'(i_magnitude_q) * (2*MAG_BITS + 1)'(i_magnitude_q);
        hi_sq  = (2*MAG_BITS + 1)'(mag_p1) * (2*MAG_BITS + 1)'(mag_p1);
    end

    // no beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // a stalled beat holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_diff_x)
            && $stable(i_diff_y) && $stable(i_magnitude_q) && $stable(i_out_row)
            && $stable(i_out_col) && $stable(i_last_of_item) && $stable(i_end_of_frame))
        else $error("stalled result beat changed");

    // the frame corner always closes its pixel's results
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_end_of_frame |-> i_last_of_item)
        else $error("end of frame without last of item");

    // magnitude is the floor root of four times the sum of squares
    a_mag_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((2*MAG_BITS + 1)'(sum4) >= lo_sq)
            && ((2*MAG_BITS + 1)'(sum4) < hi_sq))
        else $error("magnitude does not match differences");

endmodule

bind central_difference_gradient_magnitude_top cdg_checker u_cdg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_diff_x       (o_res.diff_x),
    .i_diff_y       (o_res.diff_y),
    .i_magnitude_q  (o_res.magnitude_q),
    .i_out_row      (o_res.out_row),
    .i_out_col      (o_res.out_col),
    .i_last_of_item (o_res.last_of_item),
    .i_end_of_frame (o_res.end_of_frame)
);

@@ sim/tb.sv @@
// tb: self-checking bench for central_difference_gradient_magnitude_top, streams raster frames
// through valid/ready channels and checks every result beat against an in-bench predictor.
// Depends on cdg_pkg, the cdg channel interfaces and the top module.
`timescale 1ns / 100ps

module tb;
    import cdg_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    // longest quiet stretch of the back after the last result, with margin
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int REPORT_LIMIT  = 10;
    localparam int MODE_PIXELS   = 50;
    // sides of the frames whose other side is clamped up to two
    localparam int WIDE_SIDE     = 16;
    localparam int TALL_SIDE     = 12;

    // one result beat as seen on o_res
    typedef struct packed {
        t_diff  dx;
        t_diff  dy;
        t_mag   mag;
        t_coord row;
        t_coord col;
        logic   last;
        logic   eof;
    } t_grad_beat;

    // pixel content of a frame
    typedef enum int {FILL_NOISE, FILL_BINARY, FILL_RAMP, FILL_BITS} t_fill;

    // gradient predictor and store of expected beats
    class gradient_scoreboard;
        t_dim        width_reg;
        t_dim        height_reg;
        t_pix        older_line[LINE_DEPTH];
        t_pix        recent_line[LINE_DEPTH];
        t_pix        last_pixel;
        int unsigned row_pos;
        int unsigned col_pos;
        t_grad_beat  expected_q[$];
        int unsigned mismatches;
        int unsigned beats_seen;
        int unsigned pixels_seen;

        function new();
            width_reg   = WIDTH_RESET;
            height_reg  = HEIGHT_RESET;
            last_pixel  = '0;
            row_pos     = 0;
            col_pos     = 0;
            mismatches  = 0;
            beats_seen  = 0;
            pixels_seen = 0;
        endfunction

        // any register write restarts the frame, line contents stay
        function void write_reg(t_cfg_addr addr, t_dim data);
            if (addr == CFG_WIDTH) begin
                width_reg = data;
            end else begin
                height_reg = data;
            end
            row_pos = 0;
            col_pos = 0;
        endfunction

        // floor of the square root, bit by bit from the top
        function t_mag root_q(int unsigned v);
            int unsigned acc;
            int unsigned trial;
            acc = 0;
            for (int b = 10; b >= 0; b--) begin
                trial = acc | (32'd1 << b);
                if (trial * trial <= v) acc = trial;
            end
            if (acc > 1023) acc = 1023;
            return t_mag'(acc);
        endfunction

        function void push_grad(int dx, int dy, int unsigned row, int unsigned col, logic eof);
            t_grad_beat b;
            b.dx   = t_diff'(dx);
            b.dy   = t_diff'(dy);
            b.mag  = root_q(4 * (dx * dx + dy * dy));
            b.row  = t_coord'(row);
            b.col  = t_coord'(col);
            b.last = 1'b0;
            b.eof  = eof;
            expected_q.push_back(b);
        endfunction

        // accepted pixel: predict the beats it completes, then advance the raster
        function void note_pixel(t_pix p);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            int          base;
            int          cur;
            int          left;
            int          right;
            int          up;
            int          self_v;
            t_grad_beat  tail;
            w = 32'(width_reg);
            h = 32'(height_reg);
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            if (h < MIN_DIM) h = MIN_DIM;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            r = row_pos;
            c = col_pos;
            if (c >= w) c = w - 1;
            if (r >= h) r = h - 1;
            base = expected_q.size();

            // pixel above is now complete
            if (r >= 1) begin
                cur   = int'(recent_line[c]);
                left  = (c > 0) ? int'(older_line[c - 1]) : cur;
                right = (c + 1 < w) ? int'(recent_line[c + 1]) : cur;
                up    = (r >= 2) ? int'(older_line[c]) : cur;
                push_grad(right - left, int'(p) - up, r - 1, c, 1'b0);
            end
            // bottom row trails by one column, last pixel closes itself
            if (r == h - 1) begin
                if (c >= 1) begin
                    self_v = int'(last_pixel);
                    left   = (c >= 2) ? int'(recent_line[c - 2]) : self_v;
                    up     = int'(older_line[c - 1]);
                    push_grad(int'(p) - left, self_v - up, r, c - 1, 1'b0);
                end
                if (c == w - 1) begin
                    push_grad(int'(p) - int'(last_pixel), int'(p) - int'(recent_line[c]),
                              r, c, 1'b1);
                end
            end
            if (expected_q.size() > base) begin
                tail = expected_q.pop_back();
                tail.last = 1'b1;
                expected_q.push_back(tail);
            end

            older_line[c]  = recent_line[c];
            recent_line[c] = p;
            last_pixel     = p;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
            pixels_seen++;
        endfunction

        function void check_result(t_grad_beat got);
            t_grad_beat want;
            logic       bad;
            beats_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result beat row %0d col %0d dx %0d dy %0d mag %0d",
                             got.row, got.col, got.dx, got.dy, got.mag);
                end
                return;
            end
            want = expected_q.pop_front();
            bad = (got.dx !== want.dx) || (got.dy !== want.dy) || (got.mag !== want.mag) ||
                  (got.row !== want.row) || (got.col !== want.col) ||
                  (got.last !== want.last) || (got.eof !== want.eof);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch exp dx %0d dy %0d mag %0d row %0d col %0d last %0b eof %0b",
                             want.dx, want.dy, want.mag, want.row, want.col, want.last, want.eof);
                    $display("         got dx %0d dy %0d mag %0d row %0d col %0d last %0b eof %0b",
                             got.dx, got.dy, got.mag, got.row, got.col, got.last, got.eof);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cdg_pix_if pix_ch ();
    cdg_cfg_if cfg_ch ();
    cdg_res_if res_ch ();

    central_difference_gradient_magnitude_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    gradient_scoreboard grad_sb;
    int unsigned        send_idle_pct = 27;
    int unsigned        recv_idle_pct = 47;
    int unsigned        cycle_count   = 0;
    int unsigned        settings_done = 0;
    t_grad_beat         res_beat;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // receiver back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            res_beat.dx   = res_ch.diff_x;
            res_beat.dy   = res_ch.diff_y;
            res_beat.mag  = res_ch.magnitude_q;
            res_beat.row  = res_ch.out_row;
            res_beat.col  = res_ch.out_col;
            res_beat.last = res_ch.last_of_item;
            res_beat.eof  = res_ch.end_of_frame;
            grad_sb.check_result(res_beat);
        end
    end

    task automatic write_reg(input t_cfg_addr addr, input t_dim data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        grad_sb.write_reg(addr, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one pixel beat, with random idle cycles ahead of it
    task automatic send_pixel(input t_pix p);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= p;
        do @(posedge i_clk); while (!pix_ch.ready);
        grad_sb.note_pixel(p);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (grad_sb.pending() != 0) @(posedge i_clk);
    endtask

    // block idle: all results in and trailing row-0 work finished
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(input t_dim w, input t_dim h);
        quiesce();
        if ($urandom_range(1, 0) == 1) begin
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
        end else begin
            write_reg(CFG_HEIGHT, h);
            write_reg(CFG_WIDTH, w);
        end
        settings_done++;
    endtask

    function automatic int unsigned clamp_dim(input t_dim v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic t_pix pick_pixel(input t_fill fill, input int idx);
        case (fill)
            FILL_NOISE:  return t_pix'($urandom_range(255, 0));
            FILL_BINARY: return ($urandom_range(1, 0) == 1) ? 8'hFF : 8'h00;
            FILL_RAMP:   return t_pix'(idx * 7 + $urandom_range(3, 0));
            default: begin
                if ($urandom_range(1, 0) == 1) return t_pix'(1 << $urandom_range(7, 0));
                return ~t_pix'(1 << $urandom_range(7, 0));
            end
        endcase
    endfunction

    // stream count pixels, draining once before pixel pause_at when it is in range
    task automatic send_frame(input int unsigned count, input int pause_at);
        t_fill fill;
        fill = t_fill'($urandom_range(3, 0));
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) wait_drained();
            send_pixel(pick_pixel(fill, i));
        end
    endtask

    // directed frames: flat, diagonal, steepest rising and falling corners
    localparam t_pix DIRECTED_PX[26] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'hFF, 8'hFF, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam int DIRECTED_SIDE[4] = '{2, 2, 3, 3};

    // main sequence
    initial begin
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned frame_px;
        int unsigned mode_px;
        int unsigned pick;
        int          pause_at;
        int          offset;
        logic        first_frame;
        t_dim        w_req;
        t_dim        h_req;

        grad_sb      = new();
        i_rst_n      = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr  = CFG_WIDTH;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        offset = 0;
        for (int f = 0; f < 4; f++) begin
            set_frame(t_dim'(DIRECTED_SIDE[f]), t_dim'(DIRECTED_SIDE[f]));
            for (int i = 0; i < DIRECTED_SIDE[f] * DIRECTED_SIDE[f]; i++) begin
                send_pixel(DIRECTED_PX[offset + i]);
            end
            offset += DIRECTED_SIDE[f] * DIRECTED_SIDE[f];
        end

        // random part over three idle modes
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 47 : 0;
            recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 27 : 0;
            mode_px       = 0;
            first_frame   = 1'b1;

            // wide frame with clamped height, tall frame with clamped width
            if (mode == 0) begin
                set_frame(t_dim'(WIDE_SIDE), t_dim'(1));
                send_frame(WIDE_SIDE * MIN_DIM, -1);
            end else if (mode == 1) begin
                set_frame(t_dim'(0), t_dim'(TALL_SIDE));
                send_frame(MIN_DIM * TALL_SIDE, -1);
            end

            while (mode_px < MODE_PIXELS) begin
                pick  = $urandom_range(99, 0);
                w_req = (pick < 5) ? t_dim'($urandom_range(1, 0)) :
                        (pick < 75) ? t_dim'($urandom_range(10, 2)) :
                        t_dim'($urandom_range(48, 11));
                h_req = ($urandom_range(19, 0) == 0) ? t_dim'($urandom_range(1, 0)) :
                        t_dim'($urandom_range(8, 2));
                w_eff    = clamp_dim(w_req, LINE_DEPTH);
                h_eff    = clamp_dim(h_req, MAX_HEIGHT);
                frame_px = w_eff * h_eff;
                set_frame(w_req, h_req);

                // abandoned frame, then restart through a single register write
                if ($urandom_range(4, 0) == 0) begin
                    send_frame($urandom_range(frame_px - 1, 1), -1);
                    quiesce();
                    write_reg(CFG_WIDTH, w_req);
                end

                // back-to-back frames at this size
                repeat ($urandom_range(3, 1)) begin
                    pause_at    = first_frame ? int'($urandom_range(frame_px - 1, 1)) : -1;
                    first_frame = 1'b0;
                    send_frame(frame_px, pause_at);
                    mode_px += frame_px;
                end
            end
        end

        quiesce();
        $display("covered %0d pixels, %0d result beats, %0d frame settings with sizes below two",
                 grad_sb.pixels_seen, grad_sb.beats_seen, settings_done);
        $display("clamped up, aborted frames, drain pauses, three idle mixes, %0d mismatches",
                 grad_sb.mismatches);
        if (grad_sb.mismatches == 0 && grad_sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
